[rtl/lkv_pkg.sv]
// Package with the shared word types and control codes of the LRU key-value cache.
`timescale 1ns / 1ps
package lkv_pkg;

	localparam int unsigned KEY_W   = 16;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_SET = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [VALUE_W-1:0] read_value;
	} rsp_t;

	// Broadcast update control for the row of cells.
	typedef struct packed {
		logic apply;
		logic load_key;
		logic load_value;
		logic make_valid;
	} cell_ctl_t;

endpackage

[rtl/lru_key_value_cache.sv]
// Top level of the fully associative LRU key-value cache built as a row of entry cells.
`timescale 1ns / 1ps
// A word accepted at a clock edge gives its result strobe after the lookup and update.
// Busy stays high for the lookup and the update cycles, so no new word is accepted until
// they end; a new word may be accepted in the same cycle as the previous result strobe.
// The pace is set by the cell row: ST_LOOK compares and reduces, ST_UPDATE updates.
// Reset is asynchronous and active low; it empties the cache and sets capacity to 16.
// The receiver cannot stall: each result is on rsp for exactly one cycle with done high.
module lru_key_value_cache
	import lkv_pkg::*;
#(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned KEY_BITS   = 16,
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output logic             done,
	output rsp_t             rsp
);

	// Ranks run from 0 (most recent) to DEPTH-1; the fill count runs to DEPTH itself.
	localparam int unsigned RANK_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPDATE
	} state_t;

	state_t                state_q;
	logic                  kind_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CAP_W-1:0]      cap_q;
	logic [CNT_BITS-1:0]   used_q;

	// Lookup results, registered at the end of the compare cycle.
	logic                  hit_s2;
	logic [RANK_BITS-1:0]  hit_rank_s2;
	logic [VALUE_BITS-1:0] hit_val_s2;

	// Per-cell views of the row.
	logic                  cell_match [DEPTH];
	logic                  cell_valid [DEPTH];
	logic [RANK_BITS-1:0]  cell_rank  [DEPTH];
	logic [VALUE_BITS-1:0] cell_value [DEPTH];
	logic                  cell_sel   [DEPTH];

	logic                  any_match;
	logic [RANK_BITS-1:0]  match_rank;
	logic [VALUE_BITS-1:0] match_val;
	logic [CNT_BITS-1:0]   cap_eff;
	logic                  do_fill;
	logic [RANK_BITS-1:0]  thr;
	cell_ctl_t             ctl;

	// Capacity above the built depth acts as the depth.
	always_comb begin
		if (32'(cap_q) > DEPTH) begin
			cap_eff = CNT_BITS'(DEPTH);
		end else begin
			cap_eff = CNT_BITS'(cap_q);
		end
	end

	// At most one valid cell holds a given key, so the per-cell contributions are simply
	// ORed together to give the hit, the rank of the hit entry and its value.
	always_comb begin
		any_match  = 1'b0;
		match_rank = '0;
		match_val  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			any_match  = any_match | cell_match[i];
			match_rank = match_rank | (cell_match[i] ? cell_rank[i] : '0);
			match_val  = match_val | (cell_match[i] ? cell_value[i] : '0);
		end
	end

	// Update decision. Entries are never removed, so valid cells always occupy indexes
	// 0 to used_q-1: the lowest free cell is the one at index used_q, and the least recent
	// cell is the valid one whose rank is used_q-1.
	assign do_fill = (used_q < cap_eff);

	always_comb begin
		ctl = '0;
		thr = '0;
		for (int i = 0; i < DEPTH; i++) begin
			cell_sel[i] = 1'b0;
		end
		if (state_q == ST_UPDATE) begin
			if (hit_s2) begin
				// A hit moves the entry to the front; a set also replaces the value.
				ctl.apply      = 1'b1;
				ctl.load_value = (kind_q == KIND_SET);
				thr            = hit_rank_s2;
				for (int i = 0; i < DEPTH; i++) begin
					cell_sel[i] = cell_match[i];
				end
			end else if ((kind_q == KIND_SET) && (cap_eff != '0)) begin
				ctl.apply      = 1'b1;
				ctl.load_key   = 1'b1;
				ctl.load_value = 1'b1;
				if (do_fill) begin
					// Every valid entry ages by one as the new one takes the front.
					ctl.make_valid = 1'b1;
					thr            = RANK_BITS'(used_q);
					for (int i = 0; i < DEPTH; i++) begin
						cell_sel[i] = (CNT_BITS'(i) == used_q);
					end
				end else begin
					thr = RANK_BITS'(used_q - 1'b1);
					for (int i = 0; i < DEPTH; i++) begin
						cell_sel[i] = cell_valid[i] && (cell_rank[i] == thr);
					end
				end
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		lkv_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.RANK_BITS  (RANK_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key_in   (key_q),
			.value_in (value_q),
			.ctl      (ctl),
			.sel      (cell_sel[g]),
			.thr      (thr),
			.match    (cell_match[g]),
			.valid    (cell_valid[g]),
			.rank     (cell_rank[g]),
			.value    (cell_value[g])
		);
	end

	// Sequencer, the captured word, capacity, fill count and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_GET;
			key_q       <= '0;
			value_q     <= '0;
			cap_q       <= CAP_RESET;
			used_q      <= '0;
			hit_s2      <= 1'b0;
			hit_rank_s2 <= '0;
			hit_val_s2  <= '0;
			done        <= 1'b0;
			rsp         <= '0;
		end else begin
			// The result strobe follows the update cycle and lasts one cycle.
			done <= (state_q == ST_UPDATE);
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q  <= req.kind;
						key_q   <= KEY_BITS'(req.key);
						value_q <= VALUE_BITS'(req.value);
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					hit_s2      <= any_match;
					hit_rank_s2 <= match_rank;
					hit_val_s2  <= match_val;
					state_q     <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (!hit_s2 && (kind_q == KIND_SET) && (cap_eff != '0) && do_fill) begin
						used_q <= used_q + 1'b1;
					end
					rsp.hit        <= hit_s2;
					rsp.read_value <= (hit_s2 && (kind_q == KIND_GET)) ?
						VALUE_W'(hit_val_s2) : '0;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[rtl/lkv_cell.sv]
// One cache entry: key, value, valid flag and recency rank, with its own compare.
`timescale 1ns / 1ps
module lkv_cell
	import lkv_pkg::*;
#(
	parameter int unsigned KEY_BITS   = 16,
	parameter int unsigned VALUE_BITS = 16,
	parameter int unsigned RANK_BITS  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [KEY_BITS-1:0]   key_in,
	input  logic [VALUE_BITS-1:0] value_in,
	input  cell_ctl_t             ctl,
	input  logic                  sel,
	input  logic [RANK_BITS-1:0]  thr,
	output logic                  match,
	output logic                  valid,
	output logic [RANK_BITS-1:0]  rank,
	output logic [VALUE_BITS-1:0] value
);

	logic                  valid_q;
	logic [RANK_BITS-1:0]  rank_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	// A selected cell becomes the most recent; every valid cell that was more
	// recent than the threshold ages by one rank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (ctl.apply) begin
			if (sel) begin
				rank_q <= '0;
				if (ctl.make_valid) begin
					valid_q <= 1'b1;
				end
			end else if (valid_q && (rank_q < thr)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.apply && sel) begin
			if (ctl.load_key) begin
				key_q <= key_in;
			end
			if (ctl.load_value) begin
				value_q <= value_in;
			end
		end
	end

	assign match = valid_q && (key_q == key_in);
	assign valid = valid_q;
	assign rank  = rank_q;
	assign value = value_q;

endmodule

[rtl/lkv_checker.sv]
// Port-level checks of the LRU key-value cache and the bind that attaches them.
`timescale 1ns / 1ps
module lkv_checker
	import lkv_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// An accepted word makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// Every accepted word gives its result strobe after the lookup and the update.
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result strobe missing three cycles after accept");

	// A result only follows a busy period, and the block is free while it shows.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result strobe outside a finished operation");

	// A miss never returns data.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.hit) |-> (rsp.read_value == '0))
		else $error("nonzero read value on a miss");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the LRU key-value cache: directed corner cases, then random traffic.
`timescale 1ns / 1ps
module testbench;
	import lkv_pkg::*;

	// The built depth of the cache under test. Capacity values above it act as this depth.
	localparam int SLOTS = 16;
	// Size of the key pool used by random traffic. It is a little larger than the depth,
	// so the traffic mixes hits, fills and evictions.
	localparam int POOL = 20;
	// Cycles allowed after the last result before a register write or the end of the run.
	// It is longer than the block takes to answer a word, so it leaves some margin.
	localparam int SETTLE = 6;
	// Hard stop on the run. The slowest correct run is about 1100 words, plus idle gaps
	// and the drains around register writes: well under this limit.
	localparam int LIMIT = 200000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	logic             done;
	rsp_t             rsp;

	lru_key_value_cache u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

	// Shadow copy of the cache contents. Rank 0 is the most recently used entry, and the
	// valid entries always hold the ranks 0 to used-1.
	logic [KEY_W-1:0]   shadow_key   [SLOTS];
	logic [VALUE_W-1:0] shadow_value [SLOTS];
	logic               shadow_valid [SLOTS];
	logic [3:0]         shadow_rank  [SLOTS];
	logic [4:0]         shadow_used;
	logic [CAP_W-1:0]   shadow_cap;

	// Answers owed by the block, oldest first. One word always gives one answer.
	rsp_t owed_answers [$];
	rsp_t oldest_answer;

	logic [KEY_W-1:0] key_pool [POOL];

	int fail_count;
	int cycle_count;
	int answers_checked;
	int words_sent;
	int get_count;
	int set_count;
	int hit_count;
	int fill_count;
	int evict_count;
	int cap_writes;

	always #2 clk = ~clk;

	// Move one entry to the front of the recency order. Entries that were more recent
	// than it each age by one rank; the rest keep their place.
	function automatic void bump_to_front(int idx);
		for (int i = 0; i < SLOTS; i++) begin
			if (shadow_valid[i] && i != idx && shadow_rank[i] < shadow_rank[idx])
				shadow_rank[i]++;
		end
		shadow_rank[idx] = 4'd0;
	endfunction

	// Work out the answer to one word and apply its effect to the shadow cache.
	function automatic rsp_t predict_answer(req_t w);
		rsp_t       ans;
		int         slot;
		int         limit;
		int         victim;
		logic [3:0] oldest;
		bit         seen;
		ans = '0;
		slot = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot < 0 && shadow_valid[i] && shadow_key[i] == w.key)
				slot = i;
		end
		// Capacity saturates at the built depth.
		limit = (int'(shadow_cap) > SLOTS) ? SLOTS : int'(shadow_cap);
		ans.hit = (slot >= 0);
		if (ans.hit)
			hit_count++;
		if (w.kind == KIND_GET) begin
			get_count++;
			if (slot >= 0) begin
				ans.read_value = shadow_value[slot];
				bump_to_front(slot);
			end
		end else begin
			set_count++;
			if (slot >= 0) begin
				// A set on a present key updates it, even with capacity zero.
				shadow_value[slot] = w.value;
				bump_to_front(slot);
			end else if (limit > 0) begin
				if (int'(shadow_used) < limit) begin
					// Fill the lowest free entry; every valid entry ages by one.
					slot = -1;
					for (int i = 0; i < SLOTS; i++) begin
						if (slot < 0 && !shadow_valid[i])
							slot = i;
					end
					for (int i = 0; i < SLOTS; i++) begin
						if (shadow_valid[i])
							shadow_rank[i]++;
					end
					shadow_valid[slot] = 1'b1;
					shadow_key[slot]   = w.key;
					shadow_value[slot] = w.value;
					shadow_rank[slot]  = 4'd0;
					shadow_used++;
					fill_count++;
				end else begin
					// Full, or capacity lowered below the fill level: replace the least
					// recent entry in place, so the fill level does not change.
					victim = 0;
					oldest = 4'd0;
					seen = 1'b0;
					for (int i = 0; i < SLOTS; i++) begin
						if (shadow_valid[i] && (!seen || shadow_rank[i] > oldest)) begin
							seen = 1'b1;
							oldest = shadow_rank[i];
							victim = i;
						end
					end
					shadow_key[victim]   = w.key;
					shadow_value[victim] = w.value;
					bump_to_front(victim);
					evict_count++;
				end
			end
			// With capacity zero a set on a new key stores nothing.
		end
		return ans;
	endfunction

	function automatic req_t make_word(logic kind, logic [KEY_W-1:0] key,
			logic [VALUE_W-1:0] value);
		req_t w;
		w.kind  = kind;
		w.key   = key;
		w.value = value;
		return w;
	endfunction

	// Offer one word and hold it until the block takes it. The answer is predicted at the
	// edge that accepts the word, so the shadow cache moves in the same order as the block.
	// The task returns just after a falling edge with start still high, so back-to-back
	// words keep start high without lowering it in between.
	task automatic send_word(input req_t w);
		bit taken;
		taken = 1'b0;
		start = 1'b1;
		req = w;
		while (!taken) begin
			@(posedge clk);
			if (!busy) begin
				taken = 1'b1;
				owed_answers.push_back(predict_answer(w));
				words_sent++;
			end
			@(negedge clk);
		end
	endtask

	task automatic idle_for(input int cycles);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Hold off the sender until every owed answer has come back.
	task automatic settle_cache();
		start = 1'b0;
		while (owed_answers.size() != 0)
			@(negedge clk);
	endtask

	// Capacity is only written while the block is idle: drain, let it finish its update,
	// then pulse the write enable for one cycle.
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		settle_cache();
		repeat (SETTLE) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = cap;
		@(negedge clk);
		cfg_we = 1'b0;
		shadow_cap = cap;
		cap_writes++;
	endtask

	// Gets on an empty cache miss for both extreme keys.
	task automatic test_empty_cache();
		send_word(make_word(KIND_GET, 16'h0000, 16'hFFFF));
		send_word(make_word(KIND_GET, 16'hFFFF, 16'h0000));
	endtask

	// Sets and gets at the extremes of key and value, an update in place and a miss.
	task automatic test_extreme_keys();
		send_word(make_word(KIND_SET, 16'h0000, 16'h0000));
		send_word(make_word(KIND_SET, 16'hFFFF, 16'hFFFF));
		send_word(make_word(KIND_GET, 16'hFFFF, 16'h0000));
		send_word(make_word(KIND_GET, 16'h0000, 16'hFFFF));
		send_word(make_word(KIND_SET, 16'h0000, 16'h1234));
		send_word(make_word(KIND_GET, 16'h0000, 16'h0000));
		send_word(make_word(KIND_GET, 16'h5A5A, 16'h0000));
	endtask

	// With capacity two and two keys stored, a new key pushes out the least recent one.
	task automatic test_eviction();
		set_capacity(5'd2);
		send_word(make_word(KIND_SET, 16'h0007, 16'hBEEF));
		send_word(make_word(KIND_GET, 16'hFFFF, 16'h0000));
		send_word(make_word(KIND_GET, 16'h0007, 16'h0000));
	endtask

	// Capacity zero keeps the contents: new keys are dropped, present keys still update.
	task automatic test_capacity_zero();
		set_capacity(5'd0);
		send_word(make_word(KIND_SET, 16'h0009, 16'h0001));
		send_word(make_word(KIND_GET, 16'h0009, 16'h0000));
		send_word(make_word(KIND_SET, 16'h0007, 16'h8001));
		send_word(make_word(KIND_GET, 16'h0007, 16'h0000));
	endtask

	// The largest register value acts as the built depth, so new keys fill free entries.
	task automatic test_capacity_saturates();
		set_capacity(5'd31);
		send_word(make_word(KIND_SET, 16'h0100, 16'h0A0A));
		send_word(make_word(KIND_SET, 16'h0200, 16'h0B0B));
		send_word(make_word(KIND_SET, 16'h0300, 16'h0C0C));
		send_word(make_word(KIND_GET, 16'h0100, 16'h0000));
	endtask

	// Capacity below the fill level: nothing is dropped, and a new key replaces the
	// least recent entry instead of filling.
	task automatic test_capacity_shrink();
		set_capacity(5'd3);
		send_word(make_word(KIND_SET, 16'h0400, 16'h4444));
		send_word(make_word(KIND_GET, 16'h0000, 16'h0000));
		send_word(make_word(KIND_GET, 16'h0400, 16'h0000));
	endtask

	// Random gets and sets at one capacity. Most keys come from a small pool so that
	// lookups hit and the recency order gets exercised; the rest are fresh random keys.
	// About half the pool is replaced per phase, so old contents remain reachable.
	task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int words,
			input bit gaps);
		req_t w;
		set_capacity(cap);
		for (int i = 0; i < POOL; i += 2)
			key_pool[i + $urandom_range(0, 1)] = KEY_W'($urandom);
		for (int n = 0; n < words; n++) begin
			w.kind  = $urandom_range(0, 1) ? KIND_SET : KIND_GET;
			w.key   = ($urandom_range(0, 6) == 0) ? KEY_W'($urandom)
				: key_pool[$urandom_range(0, POOL - 1)];
			w.value = VALUE_W'($urandom);
			if (gaps && $urandom_range(0, 5) == 0)
				idle_for($urandom_range(1, 12));
			// In phases with gaps, halfway through, the sender waits for every owed answer once.
			if (gaps && n == words / 2)
				settle_cache();
			send_word(w);
		end
	endtask

	// Result checker. Every strobe must match the oldest owed answer field by field.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_answers.size() == 0) begin
				$error("result with no word pending: hit %0d read_value 0x%04h",
					rsp.hit, rsp.read_value);
				fail_count++;
			end else begin
				oldest_answer = owed_answers.pop_front();
				answers_checked++;
				if (rsp.hit !== oldest_answer.hit) begin
					$error("hit: expected %0d, actual %0d", oldest_answer.hit, rsp.hit);
					fail_count++;
				end
				if (rsp.read_value !== oldest_answer.read_value) begin
					$error("read_value: expected 0x%04h, actual 0x%04h",
						oldest_answer.read_value, rsp.read_value);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("lru_key_value_cache verification failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		fail_count = 0;
		cycle_count = 0;
		answers_checked = 0;
		words_sent = 0;
		get_count = 0;
		set_count = 0;
		hit_count = 0;
		fill_count = 0;
		evict_count = 0;
		cap_writes = 0;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_key[i]   = '0;
			shadow_value[i] = '0;
			shadow_valid[i] = 1'b0;
			shadow_rank[i]  = 4'd0;
		end
		shadow_used = '0;
		shadow_cap = CAP_RESET;
		for (int i = 0; i < POOL; i++)
			key_pool[i] = KEY_W'($urandom);
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_cache();
		test_extreme_keys();
		test_eviction();
		test_capacity_zero();
		test_capacity_saturates();
		test_capacity_shrink();

		test_random_traffic(5'd16, 130, 1'b1);
		test_random_traffic(5'd1,  130, 1'b1);
		test_random_traffic(5'd4,  130, 1'b0);
		test_random_traffic(5'd31, 130, 1'b1);
		test_random_traffic(5'd0,  130, 1'b1);
		test_random_traffic(5'd2,  130, 1'b1);
		test_random_traffic(5'd9,  130, 1'b1);
		// The closing phase runs back to back with no sender gaps.
		test_random_traffic(5'd16, 130, 1'b0);

		settle_cache();
		// Linger a few cycles so a stray extra strobe would still be caught.
		repeat (SETTLE) @(negedge clk);

		$display("Sent %0d words (%0d gets, %0d sets) across %0d capacity writes; %0d answers checked.",
			words_sent, get_count, set_count, cap_writes, answers_checked);
		$display("Traffic produced %0d hits, %0d fills and %0d evictions; %0d mismatches.",
			hit_count, fill_count, evict_count, fail_count);
		if (fail_count == 0) begin
			$display("lru_key_value_cache verification clean");
		end else begin
			$display("lru_key_value_cache verification failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache.sv
rtl/lkv_checker.sv
tb/sv/testbench.sv
